// ----- src/lnorm_pkg.sv -----
// Shared constants for the layer normalizer.
package lnorm_pkg;

  localparam int unsigned DATA_W  = 16;  // sample and result field width
  localparam int unsigned NLEN_W  = 7;   // norm_length register width
  localparam int unsigned EPS_W   = 16;  // epsilon register width
  localparam int unsigned CIDX_W  = 1;   // configuration index width
  localparam int unsigned FRAC_SH = 16;  // Q16.16 to Q16.32 before square root
  localparam int unsigned Q_BITS  = 17;  // quotient bits of the output divide

  localparam logic [CIDX_W-1:0] REG_NORM_LENGTH = 1'd0;
  localparam logic [CIDX_W-1:0] REG_EPSILON     = 1'd1;

  localparam logic [DATA_W-1:0] SAT_POS = 16'h7fff;
  localparam logic [DATA_W-1:0] SAT_NEG = 16'h8000;

endpackage

// ----- src/lnorm_store.sv -----
// Two-bank sample memory, one write port and one registered read port.
module lnorm_store #(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned ADDR_W = 7
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/lnorm_queue.sv -----
// Two-entry job queue between the front and the back.
module lnorm_queue #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] ent_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = ent_q[rptr_q];

endmodule

// ----- src/lnorm_front.sv -----
// Front: configuration registers, sample loading and group closing.
module lnorm_front
  import lnorm_pkg::*;
#(
  parameter int unsigned MAX_LEN     = 64,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned LEN_W       = 7,
  parameter int unsigned IDX_W       = 6,
  parameter int unsigned SUM_W       = 22,
  parameter int unsigned JOB_W       = 46
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [CIDX_W-1:0]      cfg_index_i,
  input  logic [DATA_W-1:0]      cfg_data_i,
  input  logic                   s_valid_i,
  input  logic [DATA_W-1:0]      s_data_i,
  output logic                   s_ready_o,
  output logic                   we_o,
  output logic [IDX_W:0]         waddr_o,
  output logic [SAMPLE_BITS-1:0] wdata_o,
  output logic                   push_o,
  output logic [JOB_W-1:0]       job_o,
  input  logic                   done_i
);

  localparam int unsigned EXT_W = (SAMPLE_BITS > DATA_W) ? SAMPLE_BITS : DATA_W;

  logic [NLEN_W-1:0]      nlen_q;
  logic [EPS_W-1:0]       eps_q;
  logic [LEN_W-1:0]       fill_q;
  logic [SUM_W-1:0]       sum_q;
  logic                   bank_q;
  logic [1:0]             pend_q;

  logic [LEN_W-1:0]       eff_len;
  logic [LEN_W-1:0]       fill_nx;
  logic [SUM_W-1:0]       sum_nx;
  logic [EXT_W-1:0]       ext;
  logic [SAMPLE_BITS-1:0] x;
  logic                   acc, close;

  always_comb begin
    if (nlen_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (nlen_q > NLEN_W'(MAX_LEN)) begin
      eff_len = LEN_W'(MAX_LEN);
    end else begin
      eff_len = LEN_W'(nlen_q);
    end
  end

  assign ext     = EXT_W'(s_data_i);
  assign x       = ext[SAMPLE_BITS-1:0];
  assign s_ready_o = (pend_q != 2'd2);
  assign acc     = s_valid_i && s_ready_o;
  assign fill_nx = fill_q + LEN_W'(1);
  assign sum_nx  = sum_q + SUM_W'($signed(x));
  assign close   = acc && (fill_nx >= eff_len);

  assign we_o    = acc;
  assign waddr_o = {bank_q, fill_q[IDX_W-1:0]};
  assign wdata_o = x;
  assign push_o  = close;
  assign job_o   = {bank_q, fill_nx, sum_nx, eps_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nlen_q <= NLEN_W'(64);
      eps_q  <= EPS_W'(1);
      fill_q <= '0;
      sum_q  <= '0;
      bank_q <= 1'b0;
      pend_q <= 2'd0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_NORM_LENGTH: nlen_q <= cfg_data_i[NLEN_W-1:0];
          REG_EPSILON:     eps_q  <= cfg_data_i[EPS_W-1:0];
          default: ;
        endcase
      end
      if (close) begin
        fill_q <= '0;
        sum_q  <= '0;
        bank_q <= ~bank_q;
      end else if (acc) begin
        fill_q <= fill_nx;
        sum_q  <= sum_nx;
      end
      pend_q <= pend_q + 2'(close) - 2'(done_i);
    end
  end

endmodule

// ----- src/lnorm_back.sv -----
// Back: mean, variance, square root and per-sample divide over one buffered group.
module lnorm_back
  import lnorm_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned LEN_W       = 7,
  parameter int unsigned IDX_W       = 6,
  parameter int unsigned SUM_W       = 22,
  parameter int unsigned JOB_W       = 46
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  input  logic [JOB_W-1:0]       job_i,
  output logic                   pop_o,
  output logic [IDX_W:0]         raddr_o,
  input  logic [SAMPLE_BITS-1:0] rdata_i,
  output logic                   m_valid_o,
  output logic [DATA_W-1:0]      m_data_o,
  output logic                   m_last_o,
  input  logic                   m_ready_i,
  output logic                   done_o
);

  localparam int unsigned D_W    = SAMPLE_BITS + LEN_W + 1;
  localparam int unsigned SQ_W   = 2 * D_W + LEN_W;
  localparam int unsigned N3_W   = 3 * LEN_W;
  localparam int unsigned V_W    = SQ_W + 1;
  localparam int unsigned X_W    = ((V_W + FRAC_SH + 1) / 2) * 2;
  localparam int unsigned R_W    = X_W / 2;
  localparam int unsigned DEN_W  = LEN_W + R_W;
  localparam int unsigned CW     = (D_W + 22 > DEN_W + 19) ? D_W + 22 : DEN_W + 19;
  localparam int unsigned CNT_W  = $clog2(SQ_W + R_W + Q_BITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_N2, ST_N3, ST_RD1, ST_DEV1, ST_SQ1, ST_VDIV, ST_VADD,
    ST_SQRT, ST_DEN, ST_RD2, ST_DEV2, ST_PREP, ST_QDIV, ST_QFIN, ST_OUT
  } state_e;

  state_e            state_q;
  logic              bank_q;
  logic [LEN_W-1:0]  n_q, idx_q;
  logic [SUM_W-1:0]  s_q;
  logic [EPS_W-1:0]  eps_q;
  logic [2*LEN_W-1:0] n2_q;
  logic [N3_W-1:0]   n3_q;
  logic [D_W-1:0]    d_q;
  logic [SQ_W-1:0]   sq_q;
  logic [N3_W:0]     vrem_q;
  logic [X_W-1:0]    x_q;
  logic [R_W+1:0]    srem_q;
  logic [R_W-1:0]    root_q;
  logic [DEN_W-1:0]  den_q;
  logic [CW-1:0]     qrem_q, msh_q;
  logic [Q_BITS-1:0] q_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] y_q;
  logic              mvalid_q, mlast_q;
  logic [DATA_W-1:0] mdata_q;

  // Combinational helpers
  logic              job_bank;
  logic [LEN_W-1:0]  job_n;
  logic [SUM_W-1:0]  job_s;
  logic [EPS_W-1:0]  job_eps;
  logic [D_W-1:0]    nx, dev;
  logic              neg;
  logic [D_W-1:0]    mag;
  logic [N3_W:0]     vt;
  logic [R_W+1:0]    st, trial;
  logic [CW-1:0]     num, den_w;
  logic [V_W-1:0]    vsum;
  logic              last;
  logic              out_go;

  assign {job_bank, job_n, job_s, job_eps} = job_i;

  assign nx    = D_W'($signed({1'b0, n_q}) * $signed(rdata_i));
  assign dev   = nx - D_W'($signed(s_q));
  assign neg   = d_q[D_W-1];
  assign mag   = neg ? (~d_q + D_W'(1)) : d_q;
  assign vt    = {vrem_q[N3_W-1:0], sq_q[SQ_W-1]};
  assign st    = {srem_q[R_W-1:0], x_q[X_W-1:X_W-2]};
  assign trial = {root_q, 2'b01};
  assign den_w = CW'(den_q);
  assign num   = (CW'(mag) << 21) + den_w;
  assign vsum  = V_W'(sq_q) + V_W'(eps_q);
  assign last  = (idx_q + LEN_W'(1) == n_q);
  assign out_go = (state_q == ST_OUT) && (!mvalid_q || m_ready_i);

  assign pop_o     = (state_q == ST_IDLE) && job_valid_i;
  assign raddr_o   = {bank_q, idx_q[IDX_W-1:0]};
  assign done_o    = out_go && last;
  assign m_valid_o = mvalid_q;
  assign m_data_o  = mdata_q;
  assign m_last_o  = mlast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mvalid_q <= 1'b0;
      idx_q    <= '0;
      cnt_q    <= '0;
    end else begin
      // Drop the output item once taken, unless a new one replaces it
      if (mvalid_q && m_ready_i && !out_go) begin
        mvalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            bank_q  <= job_bank;
            n_q     <= job_n;
            s_q     <= job_s;
            eps_q   <= job_eps;
            idx_q   <= '0;
            sq_q    <= '0;
            state_q <= ST_N2;
          end
        end
        ST_N2: begin
          n2_q    <= n_q * n_q;
          state_q <= ST_N3;
        end
        ST_N3: begin
          n3_q    <= n2_q * n_q;
          state_q <= ST_RD1;
        end
        ST_RD1: state_q <= ST_DEV1;
        ST_DEV1: begin
          d_q     <= dev;
          state_q <= ST_SQ1;
        end
        ST_SQ1: begin
          sq_q <= sq_q + SQ_W'(mag * mag);
          if (last) begin
            idx_q   <= '0;
            vrem_q  <= '0;
            cnt_q   <= CNT_W'(SQ_W);
            state_q <= ST_VDIV;
          end else begin
            idx_q   <= idx_q + LEN_W'(1);
            state_q <= ST_RD1;
          end
        end
        ST_VDIV: begin
          // Long division of the squared sum by n^3, one quotient bit per cycle
          if (vt >= (N3_W + 1)'(n3_q)) begin
            vrem_q <= vt - (N3_W + 1)'(n3_q);
            sq_q   <= {sq_q[SQ_W-2:0], 1'b1};
          end else begin
            vrem_q <= vt;
            sq_q   <= {sq_q[SQ_W-2:0], 1'b0};
          end
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= ST_VADD;
          end
        end
        ST_VADD: begin
          x_q     <= X_W'({vsum, FRAC_SH'(0)});
          srem_q  <= '0;
          root_q  <= '0;
          cnt_q   <= CNT_W'(R_W);
          state_q <= ST_SQRT;
        end
        ST_SQRT: begin
          // Restoring square root, one root bit per cycle
          if (st >= trial) begin
            srem_q <= st - trial;
            root_q <= {root_q[R_W-2:0], 1'b1};
          end else begin
            srem_q <= st;
            root_q <= {root_q[R_W-2:0], 1'b0};
          end
          x_q   <= {x_q[X_W-3:0], 2'b00};
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= ST_DEN;
          end
        end
        ST_DEN: begin
          den_q   <= n_q * root_q;
          state_q <= ST_RD2;
        end
        ST_RD2: state_q <= ST_DEV2;
        ST_DEV2: begin
          d_q     <= dev;
          state_q <= ST_PREP;
        end
        ST_PREP: begin
          if (mag == '0) begin
            y_q     <= '0;
            state_q <= ST_OUT;
          end else if (root_q == '0 || num >= (den_w << 18)) begin
            y_q     <= neg ? SAT_NEG : SAT_POS;
            state_q <= ST_OUT;
          end else begin
            qrem_q  <= num;
            msh_q   <= den_w << 17;
            q_q     <= '0;
            cnt_q   <= CNT_W'(Q_BITS);
            state_q <= ST_QDIV;
          end
        end
        ST_QDIV: begin
          if (qrem_q >= msh_q) begin
            qrem_q <= qrem_q - msh_q;
            q_q    <= {q_q[Q_BITS-2:0], 1'b1};
          end else begin
            q_q    <= {q_q[Q_BITS-2:0], 1'b0};
          end
          msh_q <= msh_q >> 1;
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= ST_QFIN;
          end
        end
        ST_QFIN: begin
          if (!neg) begin
            y_q <= (q_q > Q_BITS'(32767)) ? SAT_POS : q_q[DATA_W-1:0];
          end else begin
            y_q <= (q_q > Q_BITS'(32768)) ? SAT_NEG : (~q_q[DATA_W-1:0] + DATA_W'(1));
          end
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_go) begin
            mvalid_q <= 1'b1;
            mdata_q  <= y_q;
            mlast_q  <= last;
            if (last) begin
              state_q <= ST_IDLE;
            end else begin
              idx_q   <= idx_q + LEN_W'(1);
              state_q <= ST_RD2;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/layer_normalizer_top.sv -----
// Layer normalizer top level: front, job queue, sample memory and back.
//
//   channel  | valid     | ready       | payload
//   ---------+-----------+-------------+-------------------------------------
//   samples  | s_tvalid_i| s_tready_o  | s_tdata_i[15:0] sample (Q8.8)
//   results  | m_tvalid_o| m_tready_i  | m_tdata_o[15:0] normalized, m_tlast_o
//   config   | cfg_valid_i| cfg_ready_o| cfg_index_i, cfg_data_i
//
// Samples load at one per cycle into one of two memory banks. Once a group
// closes, the back finds its variance and square root, then runs the bit-serial
// divide once per result.
// The front loads the next group while the back works and stalls only when both
// banks hold unfinished groups. Results wait in an output register.
// Reset clears all control state; memory contents are not cleared.
module layer_normalizer_top
  import lnorm_pkg::*;
#(
  parameter int unsigned MAX_LEN     = 64,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [DATA_W-1:0] s_tdata_i,   // [15:0] sample
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output logic [DATA_W-1:0] m_tdata_o,   // [15:0] normalized
  output logic              m_tlast_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [DATA_W-1:0] cfg_data_i
);

  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
  localparam int unsigned IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned SUM_W = SAMPLE_BITS + IDX_W;
  localparam int unsigned JOB_W = 1 + LEN_W + SUM_W + EPS_W;

  logic                   we, push, pop, job_valid, done;
  logic [IDX_W:0]         waddr, raddr;
  logic [SAMPLE_BITS-1:0] wdata, rdata;
  logic [JOB_W-1:0]       job_in, job_out;

  assign cfg_ready_o = 1'b1;

  lnorm_front #(
    .MAX_LEN(MAX_LEN), .SAMPLE_BITS(SAMPLE_BITS), .LEN_W(LEN_W),
    .IDX_W(IDX_W), .SUM_W(SUM_W), .JOB_W(JOB_W)
  ) u_front (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .s_valid_i(s_tvalid_i), .s_data_i(s_tdata_i), .s_ready_o(s_tready_o),
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata),
    .push_o(push), .job_o(job_in), .done_i(done)
  );

  lnorm_queue #(.WIDTH(JOB_W)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(job_in), .pop_i(pop),
    .valid_o(job_valid), .data_o(job_out)
  );

  lnorm_store #(
    .DEPTH(2 * (1 << IDX_W)), .WIDTH(SAMPLE_BITS), .ADDR_W(IDX_W + 1)
  ) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  lnorm_back #(
    .SAMPLE_BITS(SAMPLE_BITS), .LEN_W(LEN_W), .IDX_W(IDX_W),
    .SUM_W(SUM_W), .JOB_W(JOB_W)
  ) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_i(job_out), .pop_o(pop),
    .raddr_o(raddr), .rdata_i(rdata),
    .m_valid_o(m_tvalid_o), .m_data_o(m_tdata_o), .m_last_o(m_tlast_o),
    .m_ready_i(m_tready_i), .done_o(done)
  );

endmodule

// ----- test/tb_layer_normalizer_top.sv -----
// Testbench for the layer normalizer: directed and random sample groups, scored against a predictor.
module tb_layer_normalizer_top;
  import lnorm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAXLEN    = 64;
  localparam int unsigned CFG_SETTLE = 2000;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [DATA_W-1:0] norm;
    logic              last;
  } norm_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_tvalid_i = 1'b0;
  logic              s_tready_o;
  logic [DATA_W-1:0] s_tdata_i = '0;
  logic              m_tvalid_o;
  logic              m_tready_i = 1'b0;
  logic [DATA_W-1:0] m_tdata_o;
  logic              m_tlast_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CIDX_W-1:0] cfg_index_i = REG_NORM_LENGTH;
  logic [DATA_W-1:0] cfg_data_i = '0;

  layer_normalizer_top dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  logic [NLEN_W-1:0]        len_reg = 7'd64;
  logic [EPS_W-1:0]         eps_reg = 16'd1;
  logic signed [DATA_W-1:0] open_group[$];
  norm_result_t             expected_norms[$];
  int                       errors = 0;
  bit                       no_idle = 1'b0;
  int                       rdy_wait = 0;
  longint unsigned          cycles = 0;

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Buffer one sample; on group close push the normalized results.
  function automatic void predict_sample(logic signed [DATA_W-1:0] x);
    longint n, s, d, len;
    longint unsigned a, sumsq, v, r, q;
    norm_result_t res;
    len = (len_reg == 0) ? 1 : (len_reg > MAXLEN) ? MAXLEN : len_reg;
    open_group.push_back(x);
    if (open_group.size() < len) return;
    n = open_group.size();
    s = 0;
    foreach (open_group[i]) s += open_group[i];
    sumsq = 0;
    foreach (open_group[i]) begin
      d = n * open_group[i] - s;
      a = (d < 0) ? -d : d;
      sumsq += a * a;
    end
    v = sumsq / (n * n * n) + eps_reg;
    r = isqrt(v << FRAC_SH);
    foreach (open_group[i]) begin
      d = n * open_group[i] - s;
      a = (d < 0) ? -d : d;
      if (a == 0) res.norm = '0;
      else if (r == 0) res.norm = (d > 0) ? SAT_POS : SAT_NEG;
      else begin
        q = (2 * (a << 20) + n * r) / (2 * n * r);
        if (d > 0) res.norm = (q > 32767) ? SAT_POS : q[DATA_W-1:0];
        else res.norm = (q > 32768) ? SAT_NEG : DATA_W'(-q);
      end
      res.last = (i == n - 1);
      expected_norms.push_back(res);
    end
    open_group.delete();
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_layer_normalizer_top: FAIL");
      $finish;
    end
  end

  // result scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (expected_norms.size() == 0) begin
        $display("%0t: unexpected item normalized=%h last=%b", $time, m_tdata_o, m_tlast_o);
        errors++;
      end else begin
        norm_result_t e;
        e = expected_norms.pop_front();
        if (e.norm !== m_tdata_o) begin
          $display("%0t: normalized expected %h actual %h", $time, e.norm, m_tdata_o);
          errors++;
        end
        if (e.last !== m_tlast_o) begin
          $display("%0t: group_last expected %b actual %b", $time, e.last, m_tlast_o);
          errors++;
        end
      end
      rdy_wait = no_idle ? 0 : $urandom_range(0, 14);
    end
  end

  always @(negedge clk_i) begin
    if (rdy_wait > 0) begin
      m_tready_i = 1'b0;
      rdy_wait--;
    end else begin
      m_tready_i = 1'b1;
    end
  end

  task automatic send_sample(logic signed [DATA_W-1:0] x);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid_i = 1'b1;
    s_tdata_i = x;
    do @(posedge clk_i); while (!s_tready_o);
    predict_sample(x);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_tvalid_i = 1'b0;
    while (expected_norms.size() != 0) @(negedge clk_i);
    repeat (CFG_SETTLE) @(negedge clk_i);
  endtask

  // Write a register once the back end is idle.
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [DATA_W-1:0] value);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_NORM_LENGTH) len_reg = value[NLEN_W-1:0];
    else eps_reg = value[EPS_W-1:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic test_extremes();
    write_reg(REG_NORM_LENGTH, 16'd4);
    send_sample(16'sh8000); send_sample(16'sh7fff);
    send_sample(16'sh0000); send_sample(16'shffff);
    send_sample(16'sh7fff); send_sample(16'sh7fff);
    send_sample(16'sh7fff); send_sample(16'sh8000);
  endtask

  task automatic test_length_edges();
    write_reg(REG_NORM_LENGTH, 16'd0);   // acts as one
    send_sample(16'sh1234);
    write_reg(REG_NORM_LENGTH, 16'd1);
    send_sample(16'sh8000);
    write_reg(REG_NORM_LENGTH, 16'd100); // clamps to the maximum
    write_reg(REG_EPSILON, 16'hffff);
    repeat (MAXLEN) send_sample(DATA_W'($urandom));
  endtask

  task automatic test_midgroup_changes();
    write_reg(REG_NORM_LENGTH, 16'd8);
    repeat (5) send_sample(DATA_W'($urandom));
    write_reg(REG_NORM_LENGTH, 16'd3);   // shrink below the fill level
    write_reg(REG_EPSILON, 16'd300);
    send_sample(DATA_W'($urandom));
  endtask

  task automatic test_zero_denominator();
    write_reg(REG_EPSILON, 16'd0);
    write_reg(REG_NORM_LENGTH, 16'd64);
    send_sample(16'sd1);
    repeat (MAXLEN - 1) send_sample(16'sd0);
    send_sample(16'sh0100);
    repeat (MAXLEN - 1) send_sample(16'sd0);
    write_reg(REG_NORM_LENGTH, 16'd2);
    send_sample(16'sd5); send_sample(16'sd5);
  endtask

  task automatic test_random(int total);
    int sent, groups, len, mode;
    logic [DATA_W-1:0] base;
    sent = 0;
    while (sent < total) begin
      no_idle = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0: len = 64;
        1: len = $urandom_range(65, 127);
        2: len = 0;
        3: len = $urandom_range(9, 63);
        default: len = $urandom_range(1, 8);
      endcase
      write_reg(REG_NORM_LENGTH, DATA_W'(len));
      case ($urandom_range(0, 4))
        0: write_reg(REG_EPSILON, 16'd0);
        1: write_reg(REG_EPSILON, 16'hffff);
        2: write_reg(REG_EPSILON, DATA_W'($urandom));
        default: write_reg(REG_EPSILON, DATA_W'($urandom_range(0, 64)));
      endcase
      if (len == 0) len = 1;
      if (len > MAXLEN) len = MAXLEN;
      groups = (len > 16) ? 1 : $urandom_range(1, 6);
      repeat (groups * len) begin
        mode = $urandom_range(0, 3);
        base = DATA_W'($urandom);
        if (mode == 0) send_sample(DATA_W'($urandom));
        else if (mode == 1) send_sample(DATA_W'($signed($urandom_range(0, 31)) - 16));
        else if (mode == 2) send_sample(base[DATA_W-1] ? 16'sh7ff0 : 16'sh8010);
        else send_sample($signed({{4{base[11]}}, base[11:0]}));
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_extremes();
    test_length_edges();
    test_midgroup_changes();
    test_zero_denominator();
    test_random(240);
    wait_drained();
    if (errors == 0 && expected_norms.size() == 0) begin
      $display("tb_layer_normalizer_top: PASS");
    end else begin
      $display("tb_layer_normalizer_top: FAIL");
    end
    $finish;
  end

endmodule
